>>> src/escu_pkg.sv
// ============================================================================
// escu_pkg
// Shared types and constants for the environmental sensor compensation unit.
// ============================================================================
package escu_pkg;

    localparam int DIV_W = 64;

    localparam logic [63:0] PRESS_OFFSET = 64'd128000;
    localparam logic [20:0] PRESS_BASE   = 21'd1048576;
    localparam logic [11:0] PRESS_SCALE  = 12'd3125;
    localparam logic [31:0] HUM_OFFSET   = 32'd76800;
    localparam logic [31:0] HUM_ROUND    = 32'd16384;
    localparam logic [31:0] HUM_BIAS     = 32'd2097152;
    localparam logic [31:0] HUM_ROUND2   = 32'd8192;
    localparam logic [31:0] HUM_LIMIT    = 32'd419430400;

    typedef enum logic [2:0] {
        IDX_TEMP       = 3'd0,
        IDX_PRESS_LOW  = 3'd1,
        IDX_PRESS_HIGH = 3'd2,
        IDX_MIXED      = 3'd3,
        IDX_HUMID      = 3'd4
    } cfg_idx_t;

    // Side data carried alongside the pressure divide
    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        inv;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

endpackage

>>> src/env_sensor_compensation_unit.sv
// ============================================================================
// env_sensor_compensation_unit
// Integer compensation of raw temperature, pressure and humidity readings.
// ============================================================================
// Usage:
//   Input channel (s_valid/s_ready) takes one transaction per burst of raw
//   20-bit pressure, 20-bit temperature and 16-bit humidity readings.
//   Result channel (m_valid/m_ready) returns one transaction per input:
//   temperature in 0.01 degC, pressure as Q24.8 Pa with an invalid flag for
//   a zero divisor, humidity as Q22.10 percent clamped to 0..100.
//   Config channel (cfg_valid/cfg_ready) writes the packed coefficient
//   registers; cfg_ready is always high, unknown indexes are dropped.
//   Write coefficients only while no transaction is in flight.
// Timing:
//   Fully pipelined, one transaction per cycle while no result is held at the
//   output. From input accept to m_valid a transaction passes 15 front stages
//   (temperature, pressure terms, humidity), a 66-stage divider (one quotient
//   bit per stage plus sign handling), 5 post-divide stages and the output register.
// Reset and stall:
//   aresetn (synchronous, active low) clears all valid bits and zeroes the
//   coefficient registers. While a result waits with m_ready low, the whole
//   pipeline holds and s_ready drops; nothing is lost or repeated.
// ============================================================================
module env_sensor_compensation_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic        [19:0] s_raw_pressure,
    input  logic        [19:0] s_raw_temperature,
    input  logic        [15:0] s_raw_humidity,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_temperature_centi,
    output logic        [31:0] m_pressure_q24_8,
    output logic               m_pressure_invalid,
    output logic        [16:0] m_humidity_q22_10,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic         [2:0] cfg_index,
    input  logic        [63:0] cfg_data
);
    import escu_pkg::*;

    localparam int FRONT = 15;
    localparam int POST  = 5;

    // ------------------------------------------------------------------
    // Coefficient registers
    // ------------------------------------------------------------------
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_lo_reg;
    logic [63:0] press_hi_reg;
    logic [47:0] mixed_reg;
    logic [31:0] humid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg <= '0;
            press_lo_reg    <= '0;
            press_hi_reg    <= '0;
            mixed_reg       <= '0;
            humid_reg       <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                IDX_TEMP:       temp_coeffs_reg <= cfg_data[47:0];
                IDX_PRESS_LOW:  press_lo_reg    <= cfg_data;
                IDX_PRESS_HIGH: press_hi_reg    <= cfg_data;
                IDX_MIXED:      mixed_reg       <= cfg_data[47:0];
                IDX_HUMID:      humid_reg       <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // coefficient fields
    logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2;
    logic [7:0]  h1, h3, h6;
    logic [11:0] h4, h5;
    assign t1 = temp_coeffs_reg[15:0];
    assign t2 = temp_coeffs_reg[31:16];
    assign t3 = temp_coeffs_reg[47:32];
    assign p1 = press_lo_reg[15:0];
    assign p2 = press_lo_reg[31:16];
    assign p3 = press_lo_reg[47:32];
    assign p4 = press_lo_reg[63:48];
    assign p5 = press_hi_reg[15:0];
    assign p6 = press_hi_reg[31:16];
    assign p7 = press_hi_reg[47:32];
    assign p8 = press_hi_reg[63:48];
    assign p9 = mixed_reg[15:0];
    assign h1 = mixed_reg[23:16];
    assign h2 = mixed_reg[39:24];
    assign h3 = mixed_reg[47:40];
    assign h4 = humid_reg[11:0];
    assign h5 = humid_reg[23:12];
    assign h6 = humid_reg[31:24];

    // ------------------------------------------------------------------
    // Global advance: the pipeline moves unless a result is held
    // ------------------------------------------------------------------
    logic adv;
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    logic [FRONT:1] fvld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fvld_reg <= '0;
        end else if (adv) begin
            fvld_reg <= {fvld_reg[FRONT-1:1], s_valid};
        end
    end

    // ------------------------------------------------------------------
    // Front stages
    // ------------------------------------------------------------------
    logic [31:0] a1_reg, b1_reg, m1_2_reg, m2_2_reg, tv1_3_reg, m3_3_reg, tf_4_reg;
    logic [19:0] rp_reg [1:8];
    logic [15:0] rh_reg [1:6];
    logic [31:0] temp_reg [5:15];
    logic [63:0] v1_5_reg, sq_6_reg, v1p5_6_reg, v1p2_6_reg;
    logic [31:0] hv_5_reg, h5v_6_reg, vh6_6_reg, vh3_6_reg;
    logic signed [48:0] s6l_7_reg, s3l_7_reg;
    logic [31:0] s6h_7_reg, s3h_7_reg;
    logic [63:0] v2a_7_reg, v1b_7_reg, v2_8_reg, v1c_8_reg;
    logic [31:0] x_reg [7:11];
    logic [31:0] y_7_reg, z_7_reg, yz_8_reg, w_9_reg, wh2_10_reg, w2_11_reg;
    logic [47:0] e1l_9_reg;
    logic [31:0] e1h_9_reg;
    logic [63:0] pn_9_reg, d_reg [10:15];
    logic [43:0] nl_10_reg;
    logic [31:0] nh_10_reg;
    logic [63:0] num_reg [11:15];
    logic [31:0] xw_reg [12:14];
    logic [31:0] ss_13_reg, th_14_reg;
    logic [16:0] hum_15_reg;

    logic [31:0] a_c, b_c, tf_c, hum_v_c, s_c;
    logic [63:0] v1_c, e_c, sum64_c;
    logic signed [67:0] sq_c;
    logic signed [49:0] v1p5_c, v1p2_c;

    assign a_c  = 32'(s_raw_temperature >> 3) - {15'b0, t1, 1'b0};
    assign b_c  = 32'(s_raw_temperature >> 4) - {16'b0, t1};
    assign tf_c = tv1_3_reg + 32'($signed(m3_3_reg) >>> 14);
    assign v1_c = {{32{tf_4_reg[31]}}, tf_4_reg} - PRESS_OFFSET;
    assign sq_c   = $signed(v1_5_reg[33:0]) * $signed(v1_5_reg[33:0]);
    assign v1p5_c = $signed(v1_5_reg[33:0]) * $signed(p5);
    assign v1p2_c = $signed(v1_5_reg[33:0]) * $signed(p2);
    assign e_c  = 64'h0000_8000_0000_0000 + v1c_8_reg;
    assign sum64_c = {16'b0, e1l_9_reg} + {e1h_9_reg, 32'b0};
    assign s_c  = 32'($signed(xw_reg[12]) >>> 15);
    assign hum_v_c = xw_reg[14] - 32'($signed(th_14_reg) >>> 4);

    always_ff @(posedge aclk) begin
        if (adv) begin
            // S1: temperature differences
            a1_reg    <= a_c;
            b1_reg    <= b_c;
            rp_reg[1] <= s_raw_pressure;
            rh_reg[1] <= s_raw_humidity;
            for (int i = 2; i <= 8; i++) rp_reg[i] <= rp_reg[i-1];
            for (int i = 2; i <= 6; i++) rh_reg[i] <= rh_reg[i-1];
            // S2
            m1_2_reg <= a1_reg * {{16{t2[15]}}, t2};
            m2_2_reg <= b1_reg * b1_reg;
            // S3
            tv1_3_reg <= 32'($signed(m1_2_reg) >>> 11);
            m3_3_reg  <= 32'($signed(m2_2_reg) >>> 12) * {{16{t3[15]}}, t3};
            // S4: fine temperature
            tf_4_reg <= tf_c;
            // S5
            temp_reg[5] <= 32'($signed((tf_4_reg << 2) + tf_4_reg + 32'd128) >>> 8);
            for (int i = 6; i <= 15; i++) temp_reg[i] <= temp_reg[i-1];
            v1_5_reg <= v1_c;
            hv_5_reg <= tf_4_reg - HUM_OFFSET;
            // S6
            sq_6_reg   <= 64'(sq_c);
            v1p5_6_reg <= 64'(v1p5_c);
            v1p2_6_reg <= 64'(v1p2_c);
            h5v_6_reg  <= hv_5_reg * {{20{h5[11]}}, h5};
            vh6_6_reg  <= hv_5_reg * {{24{h6[7]}}, h6};
            vh3_6_reg  <= hv_5_reg * {24'b0, h3};
            // S7: 64 x 16 partial products
            s6l_7_reg <= $signed({1'b0, sq_6_reg[31:0]}) * $signed(p6);
            s6h_7_reg <= sq_6_reg[63:32] * {{16{p6[15]}}, p6};
            s3l_7_reg <= $signed({1'b0, sq_6_reg[31:0]}) * $signed(p3);
            s3h_7_reg <= sq_6_reg[63:32] * {{16{p3[15]}}, p3};
            v2a_7_reg <= (v1p5_6_reg << 17) + (64'($signed(p4)) << 35);
            v1b_7_reg <= v1p2_6_reg << 12;
            x_reg[7]  <= 32'($signed({2'b0, rh_reg[6], 14'b0} - {h4, 20'b0}
                                     - h5v_6_reg + HUM_ROUND) >>> 15);
            for (int i = 8; i <= 11; i++) x_reg[i] <= x_reg[i-1];
            y_7_reg   <= 32'($signed(vh6_6_reg) >>> 10);
            z_7_reg   <= 32'($signed(vh3_6_reg) >>> 11) + 32'd32768;
            // S8
            v2_8_reg  <= 64'(s6l_7_reg) + {s6h_7_reg, 32'b0} + v2a_7_reg;
            v1c_8_reg <= 64'($signed(64'(s3l_7_reg) + {s3h_7_reg, 32'b0}) >>> 8) + v1b_7_reg;
            yz_8_reg  <= y_7_reg * z_7_reg;
            // S9
            e1l_9_reg <= e_c[31:0] * p1;
            e1h_9_reg <= e_c[63:32] * {16'b0, p1};
            pn_9_reg  <= (64'(PRESS_BASE - {1'b0, rp_reg[8]}) << 31) - v2_8_reg;
            w_9_reg   <= 32'($signed(yz_8_reg) >>> 10) + HUM_BIAS;
            // S10: divisor and scaled numerator partials
            d_reg[10]  <= 64'($signed(sum64_c) >>> 33);
            for (int i = 11; i <= 15; i++) d_reg[i] <= d_reg[i-1];
            nl_10_reg  <= pn_9_reg[31:0] * PRESS_SCALE;
            nh_10_reg  <= pn_9_reg[63:32] * {20'b0, PRESS_SCALE};
            wh2_10_reg <= w_9_reg * {{16{h2[15]}}, h2};
            // S11
            num_reg[11] <= {20'b0, nl_10_reg} + {nh_10_reg, 32'b0};
            for (int i = 12; i <= 15; i++) num_reg[i] <= num_reg[i-1];
            w2_11_reg   <= 32'($signed(wh2_10_reg + HUM_ROUND2) >>> 14);
            // S12
            xw_reg[12] <= x_reg[11] * w2_11_reg;
            for (int i = 13; i <= 14; i++) xw_reg[i] <= xw_reg[i-1];
            // S13
            ss_13_reg <= s_c * s_c;
            // S14
            th_14_reg <= 32'($signed(ss_13_reg) >>> 7) * {24'b0, h1};
            // S15: humidity clamp
            if (hum_v_c[31]) begin
                hum_15_reg <= '0;
            end else if (hum_v_c > HUM_LIMIT) begin
                hum_15_reg <= HUM_LIMIT[28:12];
            end else begin
                hum_15_reg <= hum_v_c[28:12];
            end
        end
    end

    // ------------------------------------------------------------------
    // Pressure divide; temperature, humidity and flag ride as side data
    // ------------------------------------------------------------------
    side_t       side_in, side_q;
    logic        div_vld;
    logic [63:0] div_q, div_den;

    assign side_in.temp = temp_reg[15];
    assign side_in.hum  = hum_15_reg;
    assign side_in.inv  = (d_reg[15] == 64'd0);
    assign div_den      = side_in.inv ? 64'd1 : d_reg[15];

    escu_div #(
        .W     (DIV_W),
        .TAG_W (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (fvld_reg[FRONT]),
        .num       (num_reg[15]),
        .den       (div_den),
        .tag_in    (side_in),
        .out_valid (div_vld),
        .quo       (div_q),
        .tag_out   (side_q)
    );

    // ------------------------------------------------------------------
    // Post-divide corrections
    // ------------------------------------------------------------------
    logic [POST:1] pvld_reg;
    side_t         side_reg [1:POST];
    logic [63:0]   p_reg [1:POST];
    logic [63:0]   ps_1_reg, q2_reg [2:POST], sqq_3_reg, q1_5_reg;
    logic signed [48:0] p8l_1_reg, p9l_4_reg;
    logic [31:0]   p8h_1_reg, ssc_2_reg, p9h_4_reg;
    logic [63:0]   ssl_2_reg;
    logic [63:0]   fin_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvld_reg <= '0;
        end else if (adv) begin
            pvld_reg <= {pvld_reg[POST-1:1], div_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[1] <= side_q;
            p_reg[1]    <= div_q;
            for (int i = 2; i <= POST; i++) begin
                side_reg[i] <= side_reg[i-1];
                p_reg[i]    <= p_reg[i-1];
            end
            // Q1
            ps_1_reg  <= 64'($signed(div_q) >>> 13);
            p8l_1_reg <= $signed({1'b0, div_q[31:0]}) * $signed(p8);
            p8h_1_reg <= div_q[63:32] * {{16{p8[15]}}, p8};
            // Q2: square partials
            ssl_2_reg <= ps_1_reg[31:0] * ps_1_reg[31:0];
            ssc_2_reg <= 32'(ps_1_reg[31:0] * ps_1_reg[63:32]) << 1;
            q2_reg[2] <= 64'($signed(64'(p8l_1_reg) + {p8h_1_reg, 32'b0}) >>> 19);
            for (int i = 3; i <= POST; i++) q2_reg[i] <= q2_reg[i-1];
            // Q3
            sqq_3_reg <= ssl_2_reg + {ssc_2_reg, 32'b0};
            // Q4
            p9l_4_reg <= $signed({1'b0, sqq_3_reg[31:0]}) * $signed(p9);
            p9h_4_reg <= sqq_3_reg[63:32] * {{16{p9[15]}}, p9};
            // Q5
            q1_5_reg <= 64'($signed(64'(p9l_4_reg) + {p9h_4_reg, 32'b0}) >>> 25);
        end
    end

    assign fin_c = 64'($signed(p_reg[POST] + q1_5_reg + q2_reg[POST]) >>> 8)
                 + (64'($signed(p7)) << 4);

    // ------------------------------------------------------------------
    // Output register with pressure saturation
    // ------------------------------------------------------------------
    logic [31:0] temp_o_reg, press_o_reg;
    logic        inv_o_reg;
    logic [16:0] hum_o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= pvld_reg[POST];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            temp_o_reg <= side_reg[POST].temp;
            hum_o_reg  <= side_reg[POST].hum;
            inv_o_reg  <= side_reg[POST].inv;
            if (side_reg[POST].inv || fin_c[63]) begin
                press_o_reg <= '0;
            end else if (fin_c[63:32] != 32'd0) begin
                press_o_reg <= 32'hFFFF_FFFF;
            end else begin
                press_o_reg <= fin_c[31:0];
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_temperature_centi = $signed(temp_o_reg);
    assign m_pressure_q24_8    = press_o_reg;
    assign m_pressure_invalid  = inv_o_reg;
    assign m_humidity_q22_10   = hum_o_reg;

endmodule

>>> src/escu_div.sv
// ============================================================================
// escu_div
// Pipelined signed divider, one quotient bit per stage, truncating to zero.
// ============================================================================
module escu_div #(
    parameter int W     = escu_pkg::DIV_W,
    parameter int TAG_W = escu_pkg::SIDE_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [W-1:0]     num,
    input  logic [W-1:0]     den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [W-1:0]     quo,
    output logic [TAG_W-1:0] tag_out
);
    import escu_pkg::*;

    logic [W-1:0]     rem_reg [0:W];
    logic [W-1:0]     quo_reg [0:W];
    logic [W-1:0]     dvs_reg [0:W];
    logic             neg_reg [0:W];
    logic [TAG_W-1:0] tag_reg [0:W];
    logic [W:0]       vld_reg;
    logic [W-1:0]     res_reg;
    logic [TAG_W-1:0] tago_reg;
    logic             vo_reg;

    // per-stage trial subtraction
    logic [W:0]       shifted [0:W-1];
    logic [W-1:0]     ge;

    for (genvar i = 0; i < W; i++) begin : g_step
        assign shifted[i] = {rem_reg[i], quo_reg[i][W-1]};
        assign ge[i]      = shifted[i] >= {1'b0, dvs_reg[i]};
    end

    // valid bits, including the sign fix-up stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            vo_reg  <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[W-1:0], in_valid};
            vo_reg  <= vld_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // operand magnitudes and result sign
            rem_reg[0] <= '0;
            quo_reg[0] <= num[W-1] ? (W'(0) - num) : num;
            dvs_reg[0] <= den[W-1] ? (W'(0) - den) : den;
            neg_reg[0] <= num[W-1] ^ den[W-1];
            tag_reg[0] <= tag_in;
            for (int i = 0; i < W; i++) begin
                rem_reg[i+1] <= ge[i] ? W'(shifted[i] - {1'b0, dvs_reg[i]})
                                      : W'(shifted[i]);
                quo_reg[i+1] <= {quo_reg[i][W-2:0], ge[i]};
                dvs_reg[i+1] <= dvs_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
            // sign fix-up
            res_reg  <= neg_reg[W] ? (W'(0) - quo_reg[W]) : quo_reg[W];
            tago_reg <= tag_reg[W];
        end
    end

    assign out_valid = vo_reg;
    assign quo       = res_reg;
    assign tag_out   = tago_reg;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for env_sensor_compensation_unit: drives raw bursts
// under random back-pressure, predicts the compensated readings and compares.
// ============================================================================
module tb;
    import escu_pkg::*;

    // Compensated reading, one per input transaction
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic        inv;
        logic [16:0] hum;
    } reading_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds the coefficient copy and the readings still owed
    // ------------------------------------------------------------------------
    class reading_checker;
        logic [47:0] temp_c;
        logic [63:0] press_lo;
        logic [63:0] press_hi;
        logic [47:0] mixed_c;
        logic [31:0] humid_c;
        reading_t    owed[$];
        int          errors;

        function new();
            temp_c = '0; press_lo = '0; press_hi = '0; mixed_c = '0; humid_c = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] data);
            case (idx)
                IDX_TEMP:       temp_c   = data[47:0];
                IDX_PRESS_LOW:  press_lo = data;
                IDX_PRESS_HIGH: press_hi = data;
                IDX_MIXED:      mixed_c  = data[47:0];
                IDX_HUMID:      humid_c  = data[31:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] sra32(logic [31:0] x, int n);
            return $signed(x) >>> n;
        endfunction

        function logic [63:0] sra64(logic [63:0] x, int n);
            return $signed(x) >>> n;
        endfunction

        function logic [63:0] sx16(logic [15:0] x);
            return {{48{x[15]}}, x};
        endfunction

        function reading_t compensate(logic [19:0] adc_p, logic [19:0] adc_t,
                                      logic [15:0] adc_h);
            reading_t r;
            logic [31:0] t1, t2, t3, a, b, tv1, tv2, tf, m;
            logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, num, d, q1, q2;
            logic [31:0] h1, h2, h3, h4, h5, h6, hv, x, y, z, w, s;

            // temperature, 32-bit wrap
            t1 = {16'b0, temp_c[15:0]};
            t2 = {{16{temp_c[31]}}, temp_c[31:16]};
            t3 = {{16{temp_c[47]}}, temp_c[47:32]};
            a = ({12'b0, adc_t} >> 3) - (t1 << 1);
            m = a * t2;
            tv1 = sra32(m, 11);
            b = ({12'b0, adc_t} >> 4) - t1;
            m = b * b;
            m = sra32(m, 12) * t3;
            tv2 = sra32(m, 14);
            tf = tv1 + tv2;
            r.temp = sra32(tf * 32'd5 + 32'd128, 8);

            // pressure, 64-bit wrap
            p1 = {48'b0, press_lo[15:0]};
            p2 = sx16(press_lo[31:16]);
            p3 = sx16(press_lo[47:32]);
            p4 = sx16(press_lo[63:48]);
            p5 = sx16(press_hi[15:0]);
            p6 = sx16(press_hi[31:16]);
            p7 = sx16(press_hi[47:32]);
            p8 = sx16(press_hi[63:48]);
            p9 = sx16(mixed_c[15:0]);
            v1 = {{32{tf[31]}}, tf} - PRESS_OFFSET;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) << 17);
            v2 = v2 + (p4 << 35);
            v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
            v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
            r.inv = 1'b0;
            r.press = '0;
            if (v1 == 64'd0) begin
                r.inv = 1'b1;
            end else begin
                p = {43'b0, PRESS_BASE} - {44'b0, adc_p};
                num = ((p << 31) - v2) * {52'b0, PRESS_SCALE};
                // most negative over minus one wraps to itself
                if (num == 64'h8000_0000_0000_0000 && v1 == '1) begin
                    p = num;
                end else begin
                    d = $signed(num) / $signed(v1);
                    p = d;
                end
                q1 = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
                q2 = sra64(p8 * p, 19);
                p = sra64(p + q1 + q2, 8) + (p7 << 4);
                if (p[63])
                    r.press = '0;
                else if (p > 64'hFFFF_FFFF)
                    r.press = '1;
                else
                    r.press = p[31:0];
            end

            // humidity, 32-bit wrap
            h1 = {24'b0, mixed_c[23:16]};
            h2 = {{16{mixed_c[39]}}, mixed_c[39:24]};
            h3 = {24'b0, mixed_c[47:40]};
            h4 = {{20{humid_c[11]}}, humid_c[11:0]};
            h5 = {{20{humid_c[23]}}, humid_c[23:12]};
            h6 = {{24{humid_c[31]}}, humid_c[31:24]};
            hv = tf - HUM_OFFSET;
            x = sra32(({16'b0, adc_h} << 14) - (h4 << 20) - h5 * hv + HUM_ROUND, 15);
            y = sra32(hv * h6, 10);
            z = sra32(hv * h3, 11) + 32'd32768;
            w = sra32(y * z, 10) + HUM_BIAS;
            w = sra32(w * h2 + HUM_ROUND2, 14);
            hv = x * w;
            s = sra32(hv, 15);
            m = sra32(s * s, 7) * h1;
            hv = hv - sra32(m, 4);
            if (hv[31])
                hv = '0;
            else if (hv > HUM_LIMIT)
                hv = HUM_LIMIT;
            r.hum = hv[28:12];
            return r;
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void note_input(logic [19:0] adc_p, logic [19:0] adc_t,
                                 logic [15:0] adc_h);
            owed.push_back(compensate(adc_p, adc_t, adc_h));
        endfunction

        task check_result(reading_t got);
            reading_t e;
            if (owed.size() == 0) begin
                report("result with no transaction outstanding");
                return;
            end
            e = owed.pop_front();
            if (got.temp !== e.temp)
                report($sformatf("temperature %0d, expected %0d",
                                 $signed(got.temp), $signed(e.temp)));
            if (got.press !== e.press)
                report($sformatf("pressure %0h, expected %0h", got.press, e.press));
            if (got.inv !== e.inv)
                report($sformatf("pressure invalid %b, expected %b", got.inv, e.inv));
            if (got.hum !== e.hum)
                report($sformatf("humidity %0d, expected %0d", got.hum, e.hum));
        endtask
    endclass

    localparam int          LIMIT       = 1_000_000;
    localparam int          DRAIN       = 120;
    localparam logic [2:0]  IDX_UNUSED  = 3'd7;    // no register behind this index

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [19:0] s_raw_pressure = '0;
    logic [19:0] s_raw_temperature = '0;
    logic [15:0] s_raw_humidity = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_temperature_centi;
    logic [31:0] m_pressure_q24_8;
    logic        m_pressure_invalid;
    logic [16:0] m_humidity_q22_10;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    reading_checker sb = new();
    int  cycles = 0;
    bit  hold_req = 1'b0;   // asks the receiver for one long hold-off
    bit  no_gaps = 1'b0;    // both sides run flat out while set

    env_sensor_compensation_unit dut (.*);

    always #4 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Monitor: every accepted transaction on each channel, pre-edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                sb.note_input(s_raw_pressure, s_raw_temperature, s_raw_humidity);
            if (m_valid && m_ready)
                sb.check_result({m_temperature_centi, m_pressure_q24_8,
                                 m_pressure_invalid, m_humidity_q22_10});
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus a long hold-off on request so the
    // pipeline fills and s_ready drops while the sender keeps offering
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                for (n = 0; n < 400; n++) @(posedge aclk);
            end else if (no_gaps || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                n = pick_gap();
                repeat (n + 1) @(posedge aclk);
            end
        end
    end

    task automatic send_burst(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
        int g;
        s_valid <= 1'b1;
        s_raw_pressure <= rp;
        s_raw_temperature <= rt;
        s_raw_humidity <= rh;
        do @(posedge aclk); while (!s_ready);
        g = pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic write_coeff(logic [2:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Sender side stops until every owed reading is back, then lets the
    // pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    // Random burst: mostly near typical room readings, the rest anywhere
    task automatic send_random();
        if ($urandom_range(0, 3) != 0)
            send_burst(20'(32'd415148 + $urandom_range(0, 60000) - 32'd30000),
                       20'(32'd519888 + $urandom_range(0, 60000) - 32'd30000),
                       16'(32'd30000 + $urandom_range(0, 20000) - 32'd10000));
        else
            send_burst(20'($urandom), 20'($urandom), 16'($urandom));
    endtask

    // Coefficient sets: typical factory values, extremes and random
    task automatic load_coeffs(int kind);
        logic [63:0] r [5];
        int i;
        r[0] = {16'b0, -16'sd1000, 16'sd26435, 16'd27504};
        r[1] = {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477};
        r[2] = {-16'sd14600, 16'sd15500, -16'sd7, 16'sd140};
        r[3] = {16'b0, 8'd0, 16'sd362, 8'd75, 16'sd6000};
        r[4] = {32'b0, 8'sd30, 12'sd50, 12'sd324};
        for (i = 0; i < 5; i++) begin
            case (kind)
                0: ;
                1: r[i] = '1;
                2: r[i] = '0;
                3: r[i] = {$urandom, $urandom};
                default: r[i] = r[i] ^ {$urandom_range(0, 255), $urandom_range(0, 255)};
            endcase
        end
        // the stray index must leave every register alone
        write_coeff(IDX_UNUSED, {$urandom, $urandom});
        write_coeff(IDX_TEMP, r[0]);
        write_coeff(IDX_PRESS_LOW, r[1]);
        write_coeff(IDX_PRESS_HIGH, r[2]);
        write_coeff(IDX_MIXED, r[3]);
        write_coeff(IDX_HUMID, r[4]);
    endtask

    initial begin
        int ph, k;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset coefficients: zero divisor on every transaction
        send_burst('0, '0, '0);
        send_burst('1, '1, '1);
        send_burst(20'd415148, 20'd519888, 16'd30000);
        drain();

        // Directed set on typical coefficients
        load_coeffs(0);
        send_burst(20'd415148, 20'd519888, 16'd30000);
        send_burst('0, '0, '0);
        send_burst('1, '1, '1);
        send_burst('0, '1, '0);
        send_burst('1, '0, '1);
        send_burst(20'h55555, 20'hAAAAA, 16'h5555);
        send_burst(20'hAAAAA, 20'h55555, 16'hAAAA);
        send_burst(20'd300000, 20'd400000, 16'd0);
        send_burst(20'd500000, 20'd600000, 16'hFFFF);
        send_burst(20'd415148, 20'd700000, 16'd50000);
        drain();
        // Extremes of every coefficient
        load_coeffs(1);
        send_burst('0, '0, '0);
        send_burst('1, '1, '1);
        send_burst(20'd415148, 20'd519888, 16'd30000);
        drain();

        // Random phases across several coefficient settings
        for (ph = 0; ph < 8; ph++) begin
            load_coeffs(ph % 5);
            no_gaps = (ph == 3);
            if (ph == 1) hold_req = 1'b1;
            for (k = 0; k < 220; k++) begin
                send_random();
                if (ph == 5 && k == 110) drain();
            end
            drain();
        end
        no_gaps = 1'b0;

        if (sb.errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
